/* rtl/core/integer_to_radix_digits_macros.svh */
// ----------------------------------------------------------------------------
// integer_to_radix_digits_macros
// assertion macros used by the checker file of the block
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// property checked on every rising edge, quiet while reset is asserted
`define I2RD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("i2rd assertion failed");

// property checked on every rising edge, reset included
`define I2RD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("i2rd assertion failed");

`endif

/* rtl/core/i2rd_pkg.sv */
// ----------------------------------------------------------------------------
// i2rd_pkg
// types, constants and the digit to ascii mapping of the radix converter
// ----------------------------------------------------------------------------
package i2rd_pkg;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0]  ASCII_A     = 7'h41;
  localparam logic [CHAR_W-1:0]  ASCII_Z     = 7'h5a;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // digit value 0..35 to '0'..'9', 'A'..'Z'
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_W'(d) + ASCII_ZERO;
    end else begin
      c = CHAR_W'(d) - CHAR_W'(DIGIT_TEN) + ASCII_A;
    end
    return c;
  endfunction

endpackage

/* rtl/core/integer_to_radix_digits.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// converts an unsigned integer to its ascii digit string in base 2 to 36
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid_i / in_stall_o | value_i
//  out     | output    | out_valid_o / out_stall_i | digit_char_o, last_o
//  cfg     | input     | cfg_we_i               | cfg_wdata_i (radix)
//
//  a word is accepted, then divided by bit-serial long division, one pass
//  over the whole word per digit, and its digits then leave most significant
//  first; the divider takes one quotient bit per cycle; one word is in
//  flight at a time
//  reset is asynchronous, active low, and sets the radix to ten
//  out_stall_i holds the current digit; the next word is taken only after
//  the last digit has left
//
module integer_to_radix_digits #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [i2rd_pkg::RADIX_W-1:0]  cfg_wdata_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [VALUE_BITS-1:0]         value_i,
  // output digits
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [i2rd_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                          last_o
);

  localparam int unsigned BIT_CNT_W = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W     = $clog2(VALUE_BITS + 1);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_BITS - 1);

  i2rd_pkg::state_e state_q, state_d;

  logic [i2rd_pkg::RADIX_W-1:0] radix_q;
  logic [i2rd_pkg::RADIX_W-1:0] base;

  // divider: quotient shifts out msb first, remainder collects it
  logic [VALUE_BITS-1:0]        quo_q;
  logic [i2rd_pkg::DIGIT_W-1:0] rem_q;
  logic [BIT_CNT_W-1:0]         bit_cnt_q;
  logic                         nz_q;     // some quotient bit of this pass is set

  logic [i2rd_pkg::DIGIT_W:0]   rem_shift;
  logic [i2rd_pkg::DIGIT_W:0]   rem_sub;
  logic                         q_bit;
  logic [i2rd_pkg::DIGIT_W-1:0] rem_next;
  logic                         pass_done;

  // digit stack: newest remainder (most significant digit) sits at entry 0
  logic [i2rd_pkg::DIGIT_W-1:0] stack_q [VALUE_BITS];
  logic [CNT_W-1:0]             count_q;

  logic in_acc;
  logic out_acc;
  logic push;
  logic pop;

  // handshakes
  assign in_stall_o  = (state_q != i2rd_pkg::ST_IDLE);
  assign out_valid_o = (state_q == i2rd_pkg::ST_EMIT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  // radix out of range saturates to the nearest legal base
  always_comb begin
    if (radix_q < i2rd_pkg::RADIX_MIN) begin
      base = i2rd_pkg::RADIX_MIN;
    end else if (radix_q > i2rd_pkg::RADIX_MAX) begin
      base = i2rd_pkg::RADIX_MAX;
    end else begin
      base = radix_q;
    end
  end

  // one restoring division step per cycle
  assign rem_shift = {rem_q, quo_q[VALUE_BITS-1]};
  assign rem_sub   = rem_shift - {1'b0, base};
  assign q_bit     = (rem_shift >= {1'b0, base});
  assign rem_next  = q_bit ? rem_sub[i2rd_pkg::DIGIT_W-1:0]
                           : rem_shift[i2rd_pkg::DIGIT_W-1:0];
  assign pass_done = (state_q == i2rd_pkg::ST_DIV) && (bit_cnt_q == LAST_BIT);

  assign push = pass_done;
  assign pop  = out_acc;

  // sequencing: divide until the quotient is zero, then emit the digits
  always_comb begin
    state_d = state_q;
    case (state_q)
      i2rd_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = i2rd_pkg::ST_DIV;
        end
      end
      i2rd_pkg::ST_DIV: begin
        if (pass_done && !(nz_q || q_bit)) begin
          state_d = i2rd_pkg::ST_EMIT;
        end
      end
      i2rd_pkg::ST_EMIT: begin
        if (out_acc && last_o) begin
          state_d = i2rd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = i2rd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= i2rd_pkg::ST_IDLE;
      radix_q   <= i2rd_pkg::RADIX_RESET;
      bit_cnt_q <= '0;
      nz_q      <= 1'b0;
      count_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        bit_cnt_q <= '0;
        nz_q      <= 1'b0;
        count_q   <= '0;
      end else if (state_q == i2rd_pkg::ST_DIV) begin
        if (pass_done) begin
          bit_cnt_q <= '0;
          nz_q      <= 1'b0;
          count_q   <= count_q + CNT_W'(1);
        end else begin
          bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
          nz_q      <= nz_q | q_bit;
        end
      end else if (pop) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      quo_q <= value_i;
      rem_q <= '0;
    end else if (state_q == i2rd_pkg::ST_DIV) begin
      quo_q <= {quo_q[VALUE_BITS-2:0], q_bit};
      rem_q <= pass_done ? '0 : rem_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[0] <= rem_next;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

  // output digit straight from the head of the stack
  assign digit_char_o = i2rd_pkg::digit_to_ascii(stack_q[0]);
  assign last_o       = (count_q == CNT_W'(1));

endmodule

/* rtl/core/i2rd_checker.sv */
// ----------------------------------------------------------------------------
// i2rd_checker
// port level checks of the radix converter, bound to the top level
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_macros.svh"

module i2rd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [i2rd_pkg::CHAR_W-1:0]  digit_char_o
);

  logic is_num;
  logic is_alpha;

  assign is_num   = (digit_char_o >= i2rd_pkg::ASCII_ZERO) &&
                    (digit_char_o <= i2rd_pkg::ASCII_NINE);
  assign is_alpha = (digit_char_o >= i2rd_pkg::ASCII_A) &&
                    (digit_char_o <= i2rd_pkg::ASCII_Z);

  // a stalled digit stays offered
  `I2RD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)

  // no new word while digits are still going out
  `I2RD_ASSERT(a_no_overlap, clk_i, rst_ni, out_valid_o |-> in_stall_o)

  // an accepted word blocks the input in the following cycle
  `I2RD_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)

  // only '0'..'9' and 'A'..'Z' are emitted
  `I2RD_ASSERT(a_char_range, clk_i, rst_ni, out_valid_o |-> (is_num || is_alpha))

  // reset leaves the output with nothing offered
  `I2RD_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind integer_to_radix_digits i2rd_checker u_i2rd_checker (.*);
